[hw/rtl/nnis_pkg.sv]
// Shared constants for the nearest-neighbor image scaler: field widths,
// register indexes, reset values and parameter defaults. No dependencies.
package nnis_pkg;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 16;

  // Fixed field widths
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int SRC_DIM_W = 9;
  localparam int TGT_DIM_W = 13;
  localparam int SCALE_W   = 21;
  localparam int TGT_POS_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = SCALE_W;
  localparam int PROD_W    = TGT_POS_W + SCALE_W;

  // Largest target size
  localparam int TGT_LIMIT = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_CHAN = 3'd6;

  // Register reset values
  localparam logic [SRC_DIM_W-1:0] RST_SRC_DIM = 9'd256;
  localparam logic [TGT_DIM_W-1:0] RST_TGT_DIM = 13'd256;
  localparam logic [SCALE_W-1:0]   RST_SCALE   = 21'd65536;

  // Item kinds on in_tuser
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_EMIT  = 1'b1;

endpackage

[hw/rtl/nearest_neighbor_image_scaler.sv]
// Nearest-neighbor image scaler: frame memory, store and emit address
// generation, five-stage pipeline. Depends on nnis_pkg.
// Usage:
//   Configure through cfg_we/cfg_index/cfg_wdata while the block is idle:
//   source size, target size, inverse scales (unsigned Q.FRAC_BITS) and the
//   three-channel flag. Register writes do not move the store or emit position.
//   Input items carry the pixel in in_tdata and the kind in in_tuser: a store
//   writes the next source pixel into the frame memory in raster order and
//   gives no result; an emit produces the next destination pixel.
//   Results: pixel in out_tdata, row end on out_tlast, frame end on out_tuser.
//   Channels one and two read zero in single-channel mode.
// Timing:
//   One item accepted per cycle while the output is not stalled. An emit's
//   result reaches out_* through the accept register, coordinate multiply,
//   round and clamp, address multiply-add, then the frame memory read port
//   whose registered data is the output register. Each stage holds only while
//   the stage after it is full and stalled, so a stalled receiver fills the
//   bubbles first and then backs up to in_tready.
// Reset: rst_n (synchronous) empties the pipeline, zeroes the store and emit
//   positions and reloads the registers; memory is not cleared, store first.
module nearest_neighbor_image_scaler #(
  parameter int MAX_WIDTH  = nnis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = nnis_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = nnis_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnis_pkg::CFG_W-1:0]     cfg_wdata,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [nnis_pkg::PIX_W-1:0]     in_tdata,   // channel_zero, channel_one, channel_two
  input  logic                           in_tuser,   // action
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nnis_pkg::PIX_W-1:0]     out_tdata,  // out_channel_zero, _one, _two
  output logic                           out_tlast,  // row_end
  output logic                           out_tuser   // frame_end
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW_W   = $clog2(MAX_WIDTH + 1);
  localparam int SH_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SUM_W  = nnis_pkg::PROD_W + 1;
  localparam int TW_W   = nnis_pkg::TGT_DIM_W;
  localparam int POS_W  = nnis_pkg::TGT_POS_W;
  localparam int PIX_W  = nnis_pkg::PIX_W;
  localparam int CH_W   = nnis_pkg::CHAN_W;

  // ---------------- configuration registers ----------------
  logic [nnis_pkg::SRC_DIM_W-1:0] src_w_r, src_h_r;
  logic [TW_W-1:0]                tgt_w_r, tgt_h_r;
  logic [nnis_pkg::SCALE_W-1:0]   inv_x_r, inv_y_r;
  logic                           three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnis_pkg::RST_SRC_DIM;
      src_h_r <= nnis_pkg::RST_SRC_DIM;
      tgt_w_r <= nnis_pkg::RST_TGT_DIM;
      tgt_h_r <= nnis_pkg::RST_TGT_DIM;
      inv_x_r <= nnis_pkg::RST_SCALE;
      inv_y_r <= nnis_pkg::RST_SCALE;
      three_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnis_pkg::REG_SRC_WIDTH:   src_w_r <= cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
        nnis_pkg::REG_SRC_HEIGHT:  src_h_r <= cfg_wdata[nnis_pkg::SRC_DIM_W-1:0];
        nnis_pkg::REG_TGT_WIDTH:   tgt_w_r <= cfg_wdata[TW_W-1:0];
        nnis_pkg::REG_TGT_HEIGHT:  tgt_h_r <= cfg_wdata[TW_W-1:0];
        nnis_pkg::REG_INV_SCALE_X: inv_x_r <= cfg_wdata;
        nnis_pkg::REG_INV_SCALE_Y: inv_y_r <= cfg_wdata;
        nnis_pkg::REG_THREE_CHAN:  three_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, large values clamp to the maximum.
  logic [SW_W-1:0] sw;
  logic [SH_W-1:0] sh;
  logic [TW_W-1:0] tw, th;

  always_comb begin
    if (src_w_r == '0)                      sw = SW_W'(1);
    else if (32'(src_w_r) > 32'(MAX_WIDTH)) sw = SW_W'(MAX_WIDTH);
    else                                    sw = SW_W'(src_w_r);
    if (src_h_r == '0)                       sh = SH_W'(1);
    else if (32'(src_h_r) > 32'(MAX_HEIGHT)) sh = SH_W'(MAX_HEIGHT);
    else                                     sh = SH_W'(src_h_r);
    if (tgt_w_r == '0)                               tw = TW_W'(1);
    else if (32'(tgt_w_r) > nnis_pkg::TGT_LIMIT)     tw = TW_W'(nnis_pkg::TGT_LIMIT);
    else                                             tw = tgt_w_r;
    if (tgt_h_r == '0)                               th = TW_W'(1);
    else if (32'(tgt_h_r) > nnis_pkg::TGT_LIMIT)     th = TW_W'(nnis_pkg::TGT_LIMIT);
    else                                             th = tgt_h_r;
  end

  // ---------------- pipeline valids and stage loads ----------------
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic ld0, ld1, ld2, ld3, ld4;
  logic in_acc;

  assign ld4       = !v4_r || out_tready;
  assign ld3       = !v3_r || ld4;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign ld0       = !v0_r || ld1;
  assign in_tready = ld0;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- store and emit positions ----------------
  logic [ADDR_W-1:0] pos_r, pos_nxt, waddr;
  logic [POS_W-1:0]  tc_r, tc_nxt, tr_r, tr_nxt;
  logic              row_last, frame_last;
  logic [SW_W+SH_W-1:0] total;

  always_comb begin
    total = (SW_W+SH_W)'(sw) * (SW_W+SH_W)'(sh);
    // a position past the current source size restarts at zero
    waddr = (32'(pos_r) >= 32'(total)) ? '0 : pos_r;
    pos_nxt = pos_r;
    if (in_acc && in_tuser == nnis_pkg::ACT_STORE) begin
      pos_nxt = (32'(waddr) + 32'd1 >= 32'(total)) ? '0 : ADDR_W'(32'(waddr) + 32'd1);
    end

    row_last   = (TW_W'(tc_r) + TW_W'(1)) >= tw;
    frame_last = row_last && ((TW_W'(tr_r) + TW_W'(1)) >= th);
    tc_nxt = tc_r;
    tr_nxt = tr_r;
    if (in_acc && in_tuser == nnis_pkg::ACT_EMIT) begin
      priority if (frame_last) begin
        tc_nxt = '0;
        tr_nxt = '0;
      end else if (row_last) begin
        tc_nxt = '0;
        tr_nxt = tr_r + POS_W'(1);
      end else begin
        tc_nxt = tc_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      tc_r  <= '0;
      tr_r  <= '0;
    end else begin
      pos_r <= pos_nxt;
      tc_r  <= tc_nxt;
      tr_r  <= tr_nxt;
    end
  end

  // ---------------- stage 0: accepted item ----------------
  logic              act0_r, rl0_r, fl0_r;
  logic [PIX_W-1:0]  pix0_r;
  logic [POS_W-1:0]  tc0_r, tr0_r;
  logic [ADDR_W-1:0] wa0_r;

  always_ff @(posedge clk) begin
    if (ld0) begin
      act0_r <= in_tuser;
      pix0_r <= in_tdata;
      tc0_r  <= tc_r;
      tr0_r  <= tr_r;
      wa0_r  <= waddr;
      rl0_r  <= row_last;
      fl0_r  <= frame_last;
    end
  end

  // ---------------- stage 1: coordinate products ----------------
  logic                        act1_r, rl1_r, fl1_r;
  logic [PIX_W-1:0]            pix1_r;
  logic [nnis_pkg::PROD_W-1:0] px1_r, py1_r;
  logic [ADDR_W-1:0]           wa1_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      act1_r <= act0_r;
      pix1_r <= pix0_r;
      px1_r  <= nnis_pkg::PROD_W'(tc0_r) * nnis_pkg::PROD_W'(inv_x_r);
      py1_r  <= nnis_pkg::PROD_W'(tr0_r) * nnis_pkg::PROD_W'(inv_y_r);
      wa1_r  <= wa0_r;
      rl1_r  <= rl0_r;
      fl1_r  <= fl0_r;
    end
  end

  // ---------------- stage 2: round half up, clamp to source edge ----------------
  logic [SUM_W-1:0] cx, cy;
  logic [COL_W-1:0] sc;
  logic [ROW_W-1:0] sr;

  always_comb begin
    cx = (SUM_W'(px1_r) + (SUM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    cy = (SUM_W'(py1_r) + (SUM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    sc = (cx > SUM_W'(sw - SW_W'(1))) ? COL_W'(sw - SW_W'(1)) : cx[COL_W-1:0];
    sr = (cy > SUM_W'(sh - SH_W'(1))) ? ROW_W'(sh - SH_W'(1)) : cy[ROW_W-1:0];
  end

  logic              act2_r, rl2_r, fl2_r;
  logic [PIX_W-1:0]  pix2_r;
  logic [COL_W-1:0]  sc2_r;
  logic [ROW_W-1:0]  sr2_r;
  logic [ADDR_W-1:0] wa2_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      act2_r <= act1_r;
      pix2_r <= pix1_r;
      sc2_r  <= sc;
      sr2_r  <= sr;
      wa2_r  <= wa1_r;
      rl2_r  <= rl1_r;
      fl2_r  <= fl1_r;
    end
  end

  // ---------------- stage 3: linear address ----------------
  logic [ROW_W+SW_W-1:0] rd_lin;
  assign rd_lin = (ROW_W+SW_W)'(sr2_r) * (ROW_W+SW_W)'(sw) + (ROW_W+SW_W)'(sc2_r);

  logic              act3_r, rl3_r, fl3_r;
  logic [PIX_W-1:0]  pix3_r;
  logic [ADDR_W-1:0] a3_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      act3_r <= act2_r;
      pix3_r <= pix2_r;
      a3_r   <= (act2_r == nnis_pkg::ACT_EMIT) ? ADDR_W'(rd_lin) : wa2_r;
      rl3_r  <= rl2_r;
      fl3_r  <= fl2_r;
    end
  end

  // ---------------- stage 4: frame memory, output register ----------------
  // Stores write here in item order, so an emit always sees earlier stores.
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_r;
  logic             rl4_r, fl4_r;

  always_ff @(posedge clk) begin
    if (ld4 && v3_r) begin
      if (act3_r == nnis_pkg::ACT_STORE) begin
        mem[a3_r] <= pix3_r;
      end else begin
        rd_r  <= mem[a3_r];
        rl4_r <= rl3_r;
        fl4_r <= fl3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (ld0) v0_r <= in_acc;
      if (ld1) v1_r <= v0_r;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      // stores end at the memory and leave no result
      if (ld4) v4_r <= v3_r && (act3_r == nnis_pkg::ACT_EMIT);
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = three_r ? rd_r : {{(PIX_W-CH_W){1'b0}}, rd_r[CH_W-1:0]};
  assign out_tlast  = rl4_r;
  assign out_tuser  = fl4_r;

endmodule
